/* rtl/dbra_pkg.sv */
`default_nettype none

package dbra_pkg;

   // field geometry, store sized for the largest field
   localparam int MAX_SIZE    = 16;
   localparam int STORE_COLS  = 2 * MAX_SIZE + 1;
   localparam int STORE_ROWS  = MAX_SIZE + 1;
   localparam int STORE_DEPTH = STORE_COLS * STORE_ROWS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // payload widths
   localparam int CMD_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int COL_W   = 6;
   localparam int ROW_W   = 5;
   localparam int SIZE_W  = 5;
   localparam int COUNT_W = 4;
   localparam int SYM_W   = 5;
   localparam int CHAR_W  = 7;

   // commands
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ABSORB = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   // counts and marks
   localparam logic [COUNT_W-1:0] COUNT_CAP  = 4'd14;
   localparam logic [SYM_W-1:0]   SYM_EMPTY  = 5'd0;
   localparam logic [SYM_W-1:0]   MARK_START = 5'd15;
   localparam logic [SYM_W-1:0]   MARK_END   = 5'd16;

   localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(8);
   localparam logic [COL_W-1:0]  RESET_COL  = COL_W'(8);
   localparam logic [ROW_W-1:0]  RESET_ROW  = ROW_W'(4);

   // flat store address of one cell
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
      cell_addr = ADDR_W'(row) * ADDR_W'(STORE_COLS) + ADDR_W'(col);
   endfunction

   // character for a symbol index, from " .o+=*BOX@%&#/^SE"
   function automatic logic [CHAR_W-1:0] symbol_char(input logic [SYM_W-1:0] sym);
      case (sym)
         5'd0:    symbol_char = 7'd32;
         5'd1:    symbol_char = 7'd46;
         5'd2:    symbol_char = 7'd111;
         5'd3:    symbol_char = 7'd43;
         5'd4:    symbol_char = 7'd61;
         5'd5:    symbol_char = 7'd42;
         5'd6:    symbol_char = 7'd66;
         5'd7:    symbol_char = 7'd79;
         5'd8:    symbol_char = 7'd88;
         5'd9:    symbol_char = 7'd64;
         5'd10:   symbol_char = 7'd37;
         5'd11:   symbol_char = 7'd38;
         5'd12:   symbol_char = 7'd35;
         5'd13:   symbol_char = 7'd47;
         5'd14:   symbol_char = 7'd94;
         5'd15:   symbol_char = 7'd83;
         5'd16:   symbol_char = 7'd69;
         default: symbol_char = 7'd32;
      endcase
   endfunction

endpackage

`default_nettype wire

/* rtl/dbra_ram.sv */
`default_nettype none

module dbra_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 561,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/drunken_bishop_random_art.sv */
`default_nettype none

// Drunken-bishop fingerprint field, cell addressed.
// req_ carries one command beat (clear, absorb byte, read cell); it is taken
// when req_valid is high and req_stall is low. req_stall is high whenever the
// sequencer is busy with the previous command.
// rsp_ carries one beat per read command only; the receiver holds it off with
// rsp_stall, and the beat stays unchanged until taken. A further command is
// accepted while a response waits; a second read then holds in its last step
// until the output register frees.
// csr_ writes field_size (ready is always high); write only while idle.
// Command sequences over the count memory:
//   clear: one memory entry zeroed per cycle, through every entry of the store
//   absorb: four moves, each a read of the next cell, then its count written back
//   read: a lookup state, then the response register loads once it is free
// Reset: field_size 8, walker at column 8 row 4, then a clearing pass
// through the whole memory during which no command is accepted.

module drunken_bishop_random_art
   import dbra_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [BYTE_W-1:0] req_digest_byte,
   input  wire logic [COL_W-1:0]  req_column,
   input  wire logic [ROW_W-1:0]  req_row,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [SYM_W-1:0]       rsp_symbol_index,
   output logic [CHAR_W-1:0]      rsp_symbol_char,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [SIZE_W-1:0] csr_field_size
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CLEAR  = 3'd1;
   localparam logic [2:0] ST_MOVE   = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_LOOKUP = 3'd4;
   localparam logic [2:0] ST_RESP   = 3'd5;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [1:0]         move_cnt_ff, move_cnt_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   walk_col_ff, walk_col_in;
   logic [ROW_W-1:0]   walk_row_ff, walk_row_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]   rsp_sym_ff, rsp_sym_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;

   logic [SIZE_W-1:0]  size_eff;
   logic [COL_W-1:0]   col_max;
   logic [ROW_W-1:0]   center_row;
   logic [COL_W:0]     x_step;
   logic [ROW_W:0]     y_step;
   logic [COL_W-1:0]   x_new;
   logic [ROW_W-1:0]   y_new;
   logic               outside;
   logic [SYM_W-1:0]   sym_calc;
   logic               slot_free;
   logic               req_take;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [COUNT_W-1:0] ram_wdata;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [COUNT_W-1:0] ram_rdata;

   // effective size and field limits
   always_comb begin
      if (size_ff == '0) begin
         size_eff = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(MAX_SIZE)) begin
         size_eff = SIZE_W'(MAX_SIZE);
      end else begin
         size_eff = size_ff;
      end
      col_max    = {size_eff, 1'b0};
      center_row = ROW_W'((size_eff + SIZE_W'(1)) >> 1);
   end

   // shared move unit: one step of the walker, clamped to the field
   always_comb begin
      if (byte_ff[0]) begin
         x_step = (COL_W+1)'(walk_col_ff) + (COL_W+1)'(1);
      end else if (walk_col_ff == '0) begin
         x_step = '0;
      end else begin
         x_step = (COL_W+1)'(walk_col_ff) - (COL_W+1)'(1);
      end
      if (byte_ff[1]) begin
         y_step = (ROW_W+1)'(walk_row_ff) + (ROW_W+1)'(1);
      end else if (walk_row_ff == '0) begin
         y_step = '0;
      end else begin
         y_step = (ROW_W+1)'(walk_row_ff) - (ROW_W+1)'(1);
      end
      x_new = (x_step > (COL_W+1)'(col_max))  ? col_max  : x_step[COL_W-1:0];
      y_new = (y_step > (ROW_W+1)'(size_eff)) ? size_eff : y_step[ROW_W-1:0];
   end

   // symbol of the requested cell, marks applied here
   always_comb begin
      outside = (col_ff > col_max) || (row_ff > size_eff);
      if (outside) begin
         sym_calc = SYM_EMPTY;
      end else if (col_ff == walk_col_ff && row_ff == walk_row_ff) begin
         sym_calc = MARK_END;
      end else if (col_ff == COL_W'(size_eff) && row_ff == center_row) begin
         sym_calc = MARK_START;
      end else begin
         sym_calc = SYM_W'(ram_rdata);
      end
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_take  = req_valid && !req_stall;

   // memory port selection, a waiting read keeps its cell on the read port
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cell_addr(walk_col_ff, walk_row_ff);
      ram_wdata = (ram_rdata < COUNT_CAP) ? ram_rdata + COUNT_W'(1) : ram_rdata;
      ram_raddr = cell_addr(x_new, y_new);
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_ff;
            ram_wdata = '0;
         end
         ST_UPDATE: begin
            ram_we = 1'b1;
         end
         ST_LOOKUP, ST_RESP: begin
            ram_raddr = outside ? '0 : cell_addr(col_ff, row_ff);
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      move_cnt_in  = move_cnt_ff;
      byte_in      = byte_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      walk_col_in  = walk_col_ff;
      walk_row_in  = walk_row_ff;
      size_in      = (csr_valid && csr_ready) ? csr_field_size : size_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sym_in   = rsp_sym_ff;
      rsp_char_in  = rsp_char_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               byte_in     = req_digest_byte;
               col_in      = req_column;
               row_in      = req_row;
               move_cnt_in = '0;
               case (req_cmd)
                  CMD_CLEAR: begin
                     clr_cnt_in  = '0;
                     walk_col_in = COL_W'(size_eff);
                     walk_row_in = center_row;
                     state_in    = ST_CLEAR;
                  end
                  CMD_ABSORB: state_in = ST_MOVE;
                  CMD_READ:   state_in = ST_LOOKUP;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_MOVE: begin
            walk_col_in = x_new;
            walk_row_in = y_new;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            byte_in     = byte_ff >> 2;
            move_cnt_in = move_cnt_ff + 2'd1;
            state_in    = (move_cnt_ff == 2'd3) ? ST_IDLE : ST_MOVE;
         end
         ST_LOOKUP: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_sym_in   = sym_calc;
               rsp_char_in  = symbol_char(sym_calc);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         move_cnt_ff  <= '0;
         walk_col_ff  <= RESET_COL;
         walk_row_ff  <= RESET_ROW;
         size_ff      <= RESET_SIZE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         move_cnt_ff  <= move_cnt_in;
         walk_col_ff  <= walk_col_in;
         walk_row_ff  <= walk_row_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_char_ff <= rsp_char_in;
   end

   // visit-count store
   dbra_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (STORE_DEPTH)
   ) u_counts (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol_index = rsp_sym_ff;
   assign rsp_symbol_char  = rsp_char_ff;

   // clearing pass stays inside the store
   a_clear_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (clr_cnt_ff <= LAST_ADDR))
      else $error("clear counter past last entry");

   // walker always inside the store layout
   a_walker_range: assert property (@(posedge clock) disable iff (reset)
      (walk_col_ff <= COL_W'(2 * MAX_SIZE)) && (walk_row_ff <= ROW_W'(MAX_SIZE)))
      else $error("walker outside store");

   // memory written only by clear pass or move write-back
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_UPDATE))
      else $error("unexpected count write");

   // a pending read waits while the output register is full and stalled
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_RESP))
      else $error("response overwritten");

   // delivered index is a real symbol and matches its character
   a_sym_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sym_ff <= MARK_END && rsp_char_ff == symbol_char(rsp_sym_ff)))
      else $error("bad symbol on response");

endmodule

`default_nettype wire
